/* sv/sacm_pkg.sv */
// Package with the types, codes and threshold functions of the sensor alarm cooldown monitor.
package sacm_pkg;

  localparam int NUM_TYPES = 6;

  localparam logic ACT_CHECK  = 1'b0;
  localparam logic ACT_RECORD = 1'b1;

  localparam logic [2:0] CH_VOLT     = 3'd0;
  localparam logic [2:0] CH_TEMP     = 3'd1;
  localparam logic [2:0] CH_PRESS_HI = 3'd2;
  localparam logic [2:0] CH_PRESS_LO = 3'd3;
  localparam logic [2:0] CH_CURRENT  = 3'd4;

  localparam logic [2:0] AT_VOLT_HIGH  = 3'd0;
  localparam logic [2:0] AT_VOLT_LOW   = 3'd1;
  localparam logic [2:0] AT_TEMP       = 3'd2;
  localparam logic [2:0] AT_PRESS_HIGH = 3'd3;
  localparam logic [2:0] AT_PRESS_LOW  = 3'd4;
  localparam logic [2:0] AT_OVERCUR    = 3'd5;

  localparam logic [1:0] LVL_OK   = 2'd0;
  localparam logic [1:0] LVL_WARN = 2'd1;
  localparam logic [1:0] LVL_CRIT = 2'd2;

  localparam logic [2:0] REG_VOLT_HIGH  = 3'd0;
  localparam logic [2:0] REG_VOLT_LOW   = 3'd1;
  localparam logic [2:0] REG_TEMP       = 3'd2;
  localparam logic [2:0] REG_PRESS_HIGH = 3'd3;
  localparam logic [2:0] REG_PRESS_LOW  = 3'd4;
  localparam logic [2:0] REG_CURRENT    = 3'd5;
  localparam logic [2:0] REG_COOLDOWN   = 3'd6;

  localparam logic [31:0] COOLDOWN_RESET = 32'd300000;

  typedef struct packed {
    logic               action;
    logic [2:0]         channel;
    logic signed [15:0] sample_value;
    logic [2:0]         alert_kind;
    logic [31:0]        now_ms;
  } item_t;

  typedef struct packed {
    logic [1:0]           alert_level;
    logic [2:0]           alert_type;
    logic                 send_request;
    logic [NUM_TYPES-1:0] active_mask;
  } result_t;

  function automatic logic [1:0] level_high(logic signed [15:0] s, logic [31:0] lim);
    logic [1:0] lvl;
    if (s >= $signed(lim[31:16])) begin
      lvl = LVL_CRIT;
    end else if (s >= $signed(lim[15:0])) begin
      lvl = LVL_WARN;
    end else begin
      lvl = LVL_OK;
    end
    return lvl;
  endfunction

  function automatic logic [1:0] level_low(logic signed [15:0] s, logic [31:0] lim);
    logic [1:0] lvl;
    if (s <= $signed(lim[31:16])) begin
      lvl = LVL_CRIT;
    end else if (s <= $signed(lim[15:0])) begin
      lvl = LVL_WARN;
    end else begin
      lvl = LVL_OK;
    end
    return lvl;
  endfunction

endpackage

/* sv/sacm_if.sv */
// Valid/ready channel interfaces for the input items and the results.
interface sacm_item_if import sacm_pkg::*; ;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sacm_result_if import sacm_pkg::*; ;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/sensor_alarm_cooldown_monitor.sv */
// Top level of the sensor alarm cooldown monitor: classification, cooldown state and output stage.
//
//   Channel   Direction  Payload   Handshake
//   items     sink       item_t    valid/ready
//   results   source     result_t  valid/ready
//   cfg       write      32 bits   cfg_write, cfg_index
//
// Each item transaction produces one registered result; one item per cycle while ready is high.
// The state update and the classification happen in the cycle of acceptance.
// Reset clears the limits, the stored alert times and the active flags; cooldown is 300000.
// A result waits in the output register and one more in a skid register, so an item is still
// taken in a cycle where the output stalls; ready then falls while the skid register is full.
module sensor_alarm_cooldown_monitor import sacm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  sacm_item_if.sink     items,
  sacm_result_if.source results
);

  logic [31:0] volt_high_lim;
  logic [31:0] volt_low_lim;
  logic [31:0] temp_lim;
  logic [31:0] press_high_lim;
  logic [31:0] press_low_lim;
  logic [31:0] current_lim;
  logic [31:0] cooldown;

  logic [31:0]          last_sent [NUM_TYPES];
  logic [NUM_TYPES-1:0] active_flags;

  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;

  logic                 accept;
  logic                 space;
  result_t              res;
  logic [NUM_TYPES-1:0] flags_next;
  logic                 time_write;
  logic [2:0]           time_idx;
  logic [31:0]          time_val;
  logic [31:0]          hi_lim;
  logic [31:0]          lo_lim;
  logic [1:0]           hi_lvl;
  logic [1:0]           lo_lvl;
  logic                 chan_ok;
  logic [31:0]          last_sel;
  logic [31:0]          elapsed;

  assign items.ready   = !skid_valid;
  assign accept        = items.valid && items.ready;
  assign space         = !out_valid || results.ready;
  assign results.valid = out_valid;
  assign results.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      volt_high_lim  <= '0;
      volt_low_lim   <= '0;
      temp_lim       <= '0;
      press_high_lim <= '0;
      press_low_lim  <= '0;
      current_lim    <= '0;
      cooldown       <= COOLDOWN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_VOLT_HIGH:  volt_high_lim  <= cfg_data;
        REG_VOLT_LOW:   volt_low_lim   <= cfg_data;
        REG_TEMP:       temp_lim       <= cfg_data;
        REG_PRESS_HIGH: press_high_lim <= cfg_data;
        REG_PRESS_LOW:  press_low_lim  <= cfg_data;
        REG_CURRENT:    current_lim    <= cfg_data;
        REG_COOLDOWN:   cooldown       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (items.data.channel)
      CH_TEMP:     hi_lim = temp_lim;
      CH_PRESS_HI: hi_lim = press_high_lim;
      CH_CURRENT:  hi_lim = current_lim;
      default:     hi_lim = volt_high_lim;
    endcase
    lo_lim = (items.data.channel == CH_PRESS_LO) ? press_low_lim : volt_low_lim;
  end

  assign hi_lvl = level_high(items.data.sample_value, hi_lim);
  assign lo_lvl = level_low(items.data.sample_value, lo_lim);

  always_comb begin
    res              = '0;
    res.alert_level  = LVL_OK;
    res.alert_type   = AT_VOLT_HIGH;
    res.send_request = 1'b0;
    flags_next       = active_flags;
    time_write       = 1'b0;
    time_idx         = items.data.alert_kind;
    time_val         = items.data.now_ms;
    chan_ok          = 1'b0;
    last_sel         = '0;
    elapsed          = '0;
    if (items.data.action == ACT_RECORD) begin
      if (items.data.alert_kind < 3'(NUM_TYPES)) begin
        time_write = 1'b1;
        flags_next[items.data.alert_kind] = 1'b1;
        res.alert_type = items.data.alert_kind;
      end
    end else begin
      chan_ok = 1'b1;
      case (items.data.channel)
        CH_VOLT: begin
          if (hi_lvl != LVL_OK) begin
            res.alert_level = hi_lvl;
            res.alert_type  = AT_VOLT_HIGH;
          end else begin
            res.alert_level = lo_lvl;
            res.alert_type  = (lo_lvl != LVL_OK) ? AT_VOLT_LOW : AT_VOLT_HIGH;
          end
        end
        CH_TEMP: begin
          res.alert_level = hi_lvl;
          res.alert_type  = AT_TEMP;
        end
        CH_PRESS_HI: begin
          res.alert_level = hi_lvl;
          res.alert_type  = AT_PRESS_HIGH;
        end
        CH_PRESS_LO: begin
          res.alert_level = lo_lvl;
          res.alert_type  = AT_PRESS_LOW;
        end
        CH_CURRENT: begin
          res.alert_level = hi_lvl;
          res.alert_type  = AT_OVERCUR;
        end
        default: chan_ok = 1'b0;
      endcase
      if (chan_ok) begin
        if (res.alert_level == LVL_CRIT) begin
          last_sel = (res.alert_type < 3'(NUM_TYPES)) ? last_sent[res.alert_type] : '0;
          elapsed  = items.data.now_ms - last_sel;
          if (items.data.now_ms < last_sel) begin
            // Time has wrapped: restart the cooldown reference and allow the alert.
            res.send_request = 1'b1;
            time_write       = 1'b1;
            time_idx         = res.alert_type;
            time_val         = '0;
          end else begin
            res.send_request = (elapsed >= cooldown);
          end
        end else if (res.alert_level == LVL_OK) begin
          if (items.data.channel == CH_VOLT) begin
            flags_next[AT_VOLT_HIGH] = 1'b0;
            flags_next[AT_VOLT_LOW]  = 1'b0;
          end else begin
            flags_next[res.alert_type] = 1'b0;
          end
        end
      end
    end
    res.active_mask = flags_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TYPES; i++) begin
        last_sent[i] <= '0;
      end
      active_flags <= '0;
    end else if (accept) begin
      active_flags <= flags_next;
      if (time_write) begin
        last_sent[time_idx] <= time_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (space) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= accept;
      end else begin
        out_valid  <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (space) begin
      if (skid_valid) begin
        out_data <= skid_data;
        if (accept) begin
          skid_data <= res;
        end
      end else if (accept) begin
        out_data <= res;
      end
    end else if (accept) begin
      skid_data <= res;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    results.valid && results.data.send_request |-> results.data.alert_level == LVL_CRIT)
    else $error("Send request on a result that is not critical.");

  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("Skid register holds a result while the output register is empty.");

  assert property (@(posedge clk) $past(rst) |-> active_flags == '0 && !out_valid)
    else $error("Active flags or output valid not cleared by reset.");

  assert property (@(posedge clk) disable iff (rst)
    accept && items.data.action == ACT_RECORD |-> !res.send_request
    && res.alert_level == LVL_OK)
    else $error("Record transaction produced a level or a send request.");

endmodule
